>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked at every rising edge of clk, off while rst_n is low
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> src/rfop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfop_pkg
// Types and codes shared by the ring fifo with overflow policy.
// ----------------------------------------------------------------------------
package rfop_pkg;

  localparam int DATA_W    = 64;
  localparam int CAP_W     = 11;
  localparam int STAT_W    = 3;
  localparam int POL_W     = 2;
  localparam int CFG_IDX_W = 4;

  localparam int CAP_RESET_VAL = 1024;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // full policies
  localparam logic [POL_W-1:0] POL_DISCARD   = 2'd0;
  localparam logic [POL_W-1:0] POL_REFUSE    = 2'd1;
  localparam logic [POL_W-1:0] POL_OVERWRITE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DISCARDED = 3'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERWROTE = 3'd3;
  localparam logic [STAT_W-1:0] ST_POPPED    = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_POLICY = 4'd1;

  typedef struct packed {
    logic              ok;
    logic [STAT_W-1:0] status;
    logic [CAP_W-1:0]  fill;
  } rfop_res_t;

endpackage

>>> src/rfop_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfop_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rfop_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [rfop_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [rfop_pkg::DATA_W-1:0] rd_data
);

  logic [rfop_pkg::DATA_W-1:0] slot_mem [DEPTH];
  logic [rfop_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/rfop_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfop_ctrl
// Head and count registers, full policy and slot address generation.
// ----------------------------------------------------------------------------
module rfop_ctrl #(
  parameter int AW    = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic                             step,
  input  logic                             opcode,
  input  logic [rfop_pkg::POL_W-1:0]       policy,
  input  logic [rfop_pkg::CAP_W-1:0]       eff_cap,
  output rfop_pkg::rfop_res_t              res,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic                             rd_en,
  output logic [AW-1:0]                    rd_addr
);

  localparam int SW = ((AW > rfop_pkg::CAP_W) ? AW : rfop_pkg::CAP_W) + 1;

  logic [AW-1:0]              head_r, head_nxt;
  logic [rfop_pkg::CAP_W-1:0] count_r, count_nxt;
  logic [SW-1:0]              cap_s, inc_s, sum_s;
  logic [AW-1:0]              head_inc, tail;
  logic                       full, empty;

  assign cap_s = SW'(eff_cap);
  assign inc_s = SW'(head_r) + SW'(1);
  assign sum_s = SW'(head_r) + SW'(count_r);

  // both sums stay below twice the capacity, one subtract wraps them
  assign head_inc = (inc_s >= cap_s) ? AW'(inc_s - cap_s) : AW'(inc_s);
  assign tail     = (sum_s >= cap_s) ? AW'(sum_s - cap_s) : AW'(sum_s);

  assign full  = (count_r >= eff_cap);
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    wr_addr    = tail;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    res.ok     = 1'b1;
    res.status = rfop_pkg::ST_STORED;
    case (opcode)
      rfop_pkg::OP_PUSH: begin
        if (full) begin
          case (policy)
            rfop_pkg::POL_DISCARD: begin
              res.status = rfop_pkg::ST_DISCARDED;
            end
            rfop_pkg::POL_REFUSE: begin
              res.ok     = 1'b0;
              res.status = rfop_pkg::ST_REFUSED;
            end
            default: begin
              // oldest slot takes the new word, count stays at capacity
              res.status = rfop_pkg::ST_OVERWROTE;
              wr_en      = step;
              wr_addr    = head_r;
              head_nxt   = head_inc;
            end
          endcase
        end else begin
          wr_en     = step;
          count_nxt = count_r + rfop_pkg::CAP_W'(1);
        end
      end
      default: begin
        if (empty) begin
          res.ok     = 1'b0;
          res.status = rfop_pkg::ST_EMPTY;
        end else begin
          res.status = rfop_pkg::ST_POPPED;
          rd_en      = step;
          head_nxt   = head_inc;
          count_nxt  = count_r - rfop_pkg::CAP_W'(1);
        end
      end
    endcase
    res.fill = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (step) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> src/ring_fifo_overflow_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_overflow_policy
// Ring fifo of signed 64-bit words with configurable capacity and full policy.
// ----------------------------------------------------------------------------
// the result of a request is registered and shown in the cycle after it is accepted;
//   the slot read of a pop returns through the memory's registered read port
// throughput: one request per cycle while the result side does not stall
// reset: ring empty, capacity min(1024, DEPTH), policy discard new;
//   no clearing pass, slots are only read after a push wrote them
module ring_fifo_overflow_policy #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [rfop_pkg::DATA_W-1:0]  in_push_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ok,
  output logic [rfop_pkg::STAT_W-1:0]         out_status,
  output logic signed [rfop_pkg::DATA_W-1:0]  out_pop_value,
  output logic [rfop_pkg::CAP_W-1:0]          out_fill_level,
  input  logic                                cfg_wr_en,
  input  logic [rfop_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfop_pkg::CAP_W-1:0]          cfg_wr_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((AW > rfop_pkg::CAP_W) ? AW : rfop_pkg::CAP_W) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [rfop_pkg::CAP_W-1:0] EFF_RESET =
    rfop_pkg::CAP_W'((DEPTH < rfop_pkg::CAP_RESET_VAL) ? DEPTH : rfop_pkg::CAP_RESET_VAL);

  logic [rfop_pkg::CAP_W-1:0] eff_cap_r, eff_cap_nxt;
  logic [rfop_pkg::POL_W-1:0] policy_r;
  logic                       cfg_hit, accept;

  logic                       out_valid_r, out_valid_nxt;
  rfop_pkg::rfop_res_t        res, res_r;

  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [rfop_pkg::DATA_W-1:0] rd_data;

  assign cfg_hit = cfg_wr_en && ((cfg_index == rfop_pkg::REG_CAPACITY) ||
                                 (cfg_index == rfop_pkg::REG_FULL_POLICY));

  // clamp capacity into 1..DEPTH when it is written
  always_comb begin
    if (cfg_wr_data == '0) begin
      eff_cap_nxt = rfop_pkg::CAP_W'(1);
    end else if (SW'(cfg_wr_data) > DEPTH_S) begin
      eff_cap_nxt = rfop_pkg::CAP_W'(DEPTH_S);
    end else begin
      eff_cap_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_cap_r <= EFF_RESET;
      policy_r  <= rfop_pkg::POL_DISCARD;
    end else if (cfg_wr_en) begin
      if (cfg_index == rfop_pkg::REG_CAPACITY) begin
        eff_cap_r <= eff_cap_nxt;
      end else if (cfg_index == rfop_pkg::REG_FULL_POLICY) begin
        policy_r <= cfg_wr_data[rfop_pkg::POL_W-1:0];
      end
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  rfop_ctrl #(
    .AW    (AW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_hit),
    .step    (accept),
    .opcode  (in_opcode),
    .policy  (policy_r),
    .eff_cap (eff_cap_r),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  rfop_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  // memory read data holds until the next pop is accepted
  assign out_valid      = out_valid_r;
  assign out_ok         = res_r.ok;
  assign out_status     = res_r.status;
  assign out_fill_level = res_r.fill;
  assign out_pop_value  = (res_r.status == rfop_pkg::ST_POPPED) ? rd_data : '0;

endmodule

>>> src/rfop_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfop_chk
// Port-level checks on the ring fifo results, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfop_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_ok,
  input logic [rfop_pkg::STAT_W-1:0]        out_status,
  input logic signed [rfop_pkg::DATA_W-1:0] out_pop_value,
  input logic [rfop_pkg::CAP_W-1:0]         out_fill_level
);

  // failure is reported exactly for refused pushes and empty pops
  `ASSERT_IMPL(a_ok_status, out_valid,
    out_ok == !((out_status == rfop_pkg::ST_REFUSED) || (out_status == rfop_pkg::ST_EMPTY)),
    "ok does not match status")

  // only a successful pop carries a word
  `ASSERT_IMPL(a_pop_zero, out_valid && (out_status != rfop_pkg::ST_POPPED),
    out_pop_value == '0, "pop value set on a non-pop result")

  // an empty pop leaves nothing behind, a store leaves something
  `ASSERT_IMPL(a_fill_level, out_valid,
    ((out_status != rfop_pkg::ST_EMPTY) || (out_fill_level == '0)) &&
    ((out_status != rfop_pkg::ST_STORED) || (out_fill_level != '0)),
    "fill level inconsistent with status")

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=>
    (out_valid && $stable(out_pop_value) && $stable(out_status) && $stable(out_fill_level)),
    "stalled result changed")

endmodule

bind ring_fifo_overflow_policy rfop_chk u_rfop_chk (.*);
